>>> sv/u8d_pkg.sv
// u8d_pkg: shared types and constants for the utf-8 to utf-32 decoder
// no dependencies; imported by every decoder module
package u8d_pkg;

    // result classification, matches the result_kind encoding on the output
    typedef enum logic [1:0] {
        KIND_VALID    = 2'd0,
        KIND_REPLACED = 2'd1,
        KIND_HARD     = 2'd2
    } u8d_kind_t;

    // byte classification limits
    localparam logic [7:0] ASCII_MAX = 8'd127;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] LEAD_MIN  = 8'hC0;
    localparam logic [7:0] LEAD2_MAX = 8'd223;
    localparam logic [7:0] LEAD3_MAX = 8'd239;
    localparam logic [7:0] LEAD4_MAX = 8'd247;

    // sequence lengths
    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    // code point limits
    localparam logic [20:0] MIN_CP2        = 21'd128;
    localparam logic [20:0] MIN_CP3        = 21'd2048;
    localparam logic [20:0] MIN_CP4        = 21'd65536;
    localparam logic [20:0] MAX_CP         = 21'd1114111;
    localparam logic [20:0] SURR_LOW       = 21'd55296;
    localparam logic [20:0] SURR_HIGH      = 21'd57343;
    localparam logic [20:0] REPLACEMENT_CP = 21'd65533;

    // job handed from the front end to the back end
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  len;
        u8d_kind_t   kind;
    } u8d_job_t;

endpackage

>>> sv/u8d_in_if.sv
// u8d_in_if: valid/ready channel carrying one utf-8 byte item
// depends on nothing but the handshake convention
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_input;

    modport source (output valid, output byte_value, output end_of_input, input ready);
    modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

>>> sv/u8d_out_if.sv
// u8d_out_if: valid/ready channel carrying one decoded code point item
// depends on nothing but the handshake convention
interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [1:0]  result_kind;

    modport source (output valid, output code_point, output result_kind, input ready);
    modport sink   (input valid, input code_point, input result_kind, output ready);
endinterface

>>> sv/u8d_front.sv
// u8d_front: accepts bytes, tracks the sequence state, pushes finished jobs
// depends on u8d_pkg and u8d_in_if
module u8d_front
    import u8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    u8d_in_if.sink   in_ch,
    input  logic     q_full,
    output logic     push,
    output u8d_job_t job
);

    logic [20:0] acc_reg, acc_next;
    logic [1:0]  remaining_reg, remaining_next;
    logic [2:0]  length_reg, length_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [20:0] acc_shift;
    logic [1:0]  rem_dec;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.byte_value;
    assign last        = in_ch.end_of_input;
    assign acc_shift   = {acc_reg[14:0], b[5:0]};
    assign rem_dec     = remaining_reg - 2'd1;

    // byte classification and sequence state update
    always_comb
    begin
        acc_next       = acc_reg;
        remaining_next = remaining_reg;
        length_next    = length_reg;
        halted_next    = halted_reg;
        push           = 1'b0;
        job.cp         = '0;
        job.len        = LEN_1;
        job.kind       = KIND_HARD;
        if (accept)
        begin
            if (halted_reg)
            begin
                // drop bytes until the end marker
                if (last)
                begin
                    halted_next    = 1'b0;
                    acc_next       = '0;
                    remaining_next = '0;
                    length_next    = '0;
                end
            end
            else if (remaining_reg == 2'd0)
            begin
                if (b <= ASCII_MAX)
                begin
                    push     = 1'b1;
                    job.cp   = {13'd0, b};
                    job.len  = LEN_1;
                    job.kind = KIND_VALID;
                    acc_next       = '0;
                    remaining_next = '0;
                    length_next    = '0;
                end
                else if (b < LEAD_MIN || b > LEAD4_MAX || last)
                begin
                    // stray continuation, invalid lead, or lead cut off by the end marker
                    push           = 1'b1;
                    acc_next       = '0;
                    remaining_next = '0;
                    length_next    = '0;
                    halted_next    = !last;
                end
                else if (b <= LEAD2_MAX)
                begin
                    acc_next       = {16'd0, b[4:0]};
                    remaining_next = 2'd1;
                    length_next    = LEN_2;
                end
                else if (b <= LEAD3_MAX)
                begin
                    acc_next       = {17'd0, b[3:0]};
                    remaining_next = 2'd2;
                    length_next    = LEN_3;
                end
                else
                begin
                    acc_next       = {18'd0, b[2:0]};
                    remaining_next = 2'd3;
                    length_next    = LEN_4;
                end
            end
            else if (b < CONT_MIN || b > CONT_MAX)
            begin
                // bad continuation, the byte is consumed
                push           = 1'b1;
                acc_next       = '0;
                remaining_next = '0;
                length_next    = '0;
                halted_next    = !last;
            end
            else if (rem_dec == 2'd0)
            begin
                // sequence complete, range checks happen in the back end
                push           = 1'b1;
                job.cp         = acc_shift;
                job.len        = length_reg;
                job.kind       = KIND_VALID;
                acc_next       = '0;
                remaining_next = '0;
                length_next    = '0;
            end
            else if (last)
            begin
                // truncated sequence
                push           = 1'b1;
                acc_next       = '0;
                remaining_next = '0;
                length_next    = '0;
                halted_next    = 1'b0;
            end
            else
            begin
                acc_next       = acc_shift;
                remaining_next = rem_dec;
            end
        end
    end

    // sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            remaining_reg <= '0;
            length_reg    <= '0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            remaining_reg <= remaining_next;
            length_reg    <= length_next;
            halted_reg    <= halted_next;
        end
    end

    // a hard error without the end marker halts decoding
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && job.kind == KIND_HARD && !last) |=> halted_reg)
        else $error("hard error did not halt decoding");

    // while halted no sequence is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (remaining_reg == 2'd0 && length_reg == 3'd0))
        else $error("sequence state left over while halted");

endmodule

>>> sv/u8d_queue.sv
// u8d_queue: small fifo of decoder jobs between front and back end
// depends on u8d_pkg
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  u8d_job_t push_job,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output u8d_job_t head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    u8d_job_t      entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head_job  = entries[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // no write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

>>> sv/u8d_back.sv
// u8d_back: range checks on finished jobs and the registered result stage
// depends on u8d_pkg and u8d_out_if
module u8d_back
    import u8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  u8d_job_t job,
    output logic     pop,
    u8d_out_if.source out_ch
);

    logic        out_valid_reg;
    logic [20:0] cp_reg, cp_next;
    u8d_kind_t   kind_reg, kind_next;
    logic        overlong, outside;

    assign pop = job_valid && (!out_valid_reg || out_ch.ready);

    // overlong, surrogate and out-of-range checks
    always_comb
    begin
        overlong = (job.len == LEN_2 && job.cp < MIN_CP2) ||
                   (job.len == LEN_3 && job.cp < MIN_CP3) ||
                   (job.len == LEN_4 && job.cp < MIN_CP4);
        outside  = (job.cp > MAX_CP) || (job.cp >= SURR_LOW && job.cp <= SURR_HIGH);
        if (job.kind == KIND_HARD)
        begin
            cp_next   = '0;
            kind_next = KIND_HARD;
        end
        else if (overlong || outside)
        begin
            cp_next   = REPLACEMENT_CP;
            kind_next = KIND_REPLACED;
        end
        else
        begin
            cp_next   = job.cp;
            kind_next = KIND_VALID;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cp_reg   <= cp_next;
            kind_reg <= kind_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.code_point  = cp_reg;
    assign out_ch.result_kind = 2'(kind_reg);

    // a hard error result carries a zero code point
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_HARD) |-> cp_reg == '0)
        else $error("hard error with nonzero code point");

    // a replacement result carries the replacement character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_REPLACED) |-> cp_reg == REPLACEMENT_CP)
        else $error("replacement with wrong code point");

endmodule

>>> sv/utf8_to_utf32_decoder_top.sv
// utf8_to_utf32_decoder_top: utf-8 byte stream in, utf-32 code points out
// a result's job passes through the job queue and then the output register
// throughput: one byte per cycle if q_full is low, set by the sequence state register
// the job queue and the output register let either side stall on its own
// reset: rst_n asynchronous active low clears sequence state, halt flag and queue
module utf8_to_utf32_decoder_top
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    u8d_in_if.sink    in_ch,
    u8d_out_if.source out_ch
);

    logic     push, pop, q_full, q_not_empty;
    u8d_job_t push_job, head_job;

    // byte classification and sequence tracking
    u8d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .job    (push_job)
    );

    // job queue
    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    // range checks and result register
    u8d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head_job),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule
